@@ sv/deq_pkg.sv @@
// Package: deque sizes, request and status codes, word and cell-control types.
`default_nettype none
package deq_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [2:0] REQ_POP_BACK   = 3'd3;
  localparam logic [2:0] REQ_PEEK       = 3'd4;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] value;
  } deq_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] front_word;
    logic signed [31:0] back_word;
    logic [4:0]         count;
    logic               not_empty;
  } deq_rsp_t;

  typedef struct packed {
    logic shift_back;   // push front: every word moves one cell back
    logic shift_front;  // pop front: every word moves one cell forward
    logic load_back;    // first empty cell loads the word
    logic drop_back;    // last held cell empties
  } deq_cell_op_t;

endpackage
`default_nettype wire

@@ sv/double_ended_queue_core.sv @@
// Double-ended queue of 32-bit words held in a shifting row of cells.
// The result strobe (done) is registered: it comes in the cycle after start is accepted.
// Throughput: one request per cycle; busy is never raised.
// The front word sits in cell 0; the back word is the last occupied cell.
// Reset (rst, synchronous): queue empty, count zero, no result pending.
// The receiver cannot stall: each result is on rsp for exactly one cycle.
`default_nettype none
module double_ended_queue_core
  import deq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  output logic          busy,
  input  wire deq_req_t req,
  output logic          done,
  output deq_rsp_t      rsp
);

  logic [31:0]      words [DEPTH];
  logic [DEPTH-1:0] occ;
  logic [DEPTH-1:0] back_hit;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [1:0]       status;
  logic [1:0]       status_next;
  logic             full;
  logic             empty;
  logic             accept;
  deq_cell_op_t     op;
  logic [31:0]      back_sel;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count == CNT_W'(DEPTH));
  assign empty  = (count == '0);

  always_comb begin
    op          = '0;
    count_next  = count;
    status_next = ST_DONE;
    if (accept) begin
      case (req.req_type)
        REQ_PUSH_FRONT: begin
          if (full) begin
            status_next = ST_FULL;
          end else begin
            op.shift_back = 1'b1;
            count_next    = count + CNT_W'(1);
          end
        end
        REQ_PUSH_BACK: begin
          if (full) begin
            status_next = ST_FULL;
          end else begin
            op.load_back = 1'b1;
            count_next   = count + CNT_W'(1);
          end
        end
        REQ_POP_FRONT: begin
          if (empty) begin
            status_next = ST_EMPTY;
          end else begin
            op.shift_front = 1'b1;
            count_next     = count - CNT_W'(1);
          end
        end
        REQ_POP_BACK: begin
          if (empty) begin
            status_next = ST_EMPTY;
          end else begin
            op.drop_back = 1'b1;
            count_next   = count - CNT_W'(1);
          end
        end
        default: begin
          status_next = ST_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      status <= ST_DONE;
      done   <= 1'b0;
    end else begin
      count  <= count_next;
      status <= status_next;
      done   <= accept;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [31:0] lw;
    logic        lo;
    logic [31:0] rw;
    logic        ro;
    if (i == 0) begin : g_first
      assign lw = req.value;
      assign lo = 1'b1;
    end else begin : g_mid
      assign lw = words[i-1];
      assign lo = occ[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign rw = '0;
      assign ro = 1'b0;
    end else begin : g_inner
      assign rw = words[i+1];
      assign ro = occ[i+1];
    end
    deq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .op         (op),
      .push_word  (req.value),
      .left_word  (lw),
      .left_occ   (lo),
      .right_word (rw),
      .right_occ  (ro),
      .word       (words[i]),
      .occ        (occ[i]),
      .is_back    (back_hit[i])
    );
  end

  always_comb begin
    back_sel = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_sel = back_sel | (words[i] & {32{back_hit[i]}});
    end
  end

  always_comb begin
    rsp.status     = status;
    rsp.front_word = occ[0] ? words[0] : '0;
    rsp.back_word  = back_sel;
    rsp.count      = 5'(count);
    rsp.not_empty  = occ[0];
  end

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(occ) == 32'(count))
    else $error("count does not match occupied cells");

  a_packed_front: assert property (@(posedge clk) disable iff (rst)
    ((occ >> 1) & ~occ) == '0)
    else $error("occupied cells not packed toward the front");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("accepted request produced no result");

  a_full_reject: assert property (@(posedge clk) disable iff (rst)
    accept && full && (req.req_type == REQ_PUSH_FRONT || req.req_type == REQ_PUSH_BACK)
    |=> rsp.status == ST_FULL && $stable(count))
    else $error("push when full not rejected");

endmodule
`default_nettype wire

@@ sv/deq_cell.sv @@
// One deque cell: a word and its occupancy flag, linked to both neighbors.
`default_nettype none
module deq_cell
  import deq_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire deq_cell_op_t op,
  input  wire logic [31:0]  push_word,
  input  wire logic [31:0]  left_word,
  input  wire logic         left_occ,
  input  wire logic [31:0]  right_word,
  input  wire logic         right_occ,
  output logic [31:0]       word,
  output logic              occ,
  output logic              is_back
);

  always_ff @(posedge clk) begin
    if (op.shift_back) begin
      word <= left_word;
    end else if (op.shift_front) begin
      word <= right_word;
    end else if (op.load_back && left_occ && !occ) begin
      word <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (op.shift_back) begin
      occ <= left_occ;
    end else if (op.shift_front) begin
      occ <= right_occ;
    end else if (op.load_back && left_occ && !occ) begin
      occ <= 1'b1;
    end else if (op.drop_back && occ && !right_occ) begin
      occ <= 1'b0;
    end
  end

  assign is_back = occ && !right_occ;

endmodule
`default_nettype wire
